>>> sv/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Widths, opcode codes, sequencer states and the modulus reset value.
// ----------------------------------------------------------------------------
package mau_pkg;

  // residue and modulus width
  localparam int MOD_W = 31;
  // signed operand width
  localparam int OP_W = 64;
  // exponent field width as used by the power opcode
  localparam int EXP_W = 64;
  // exponent register width: holds the magnitude and also modulus minus two
  localparam int E_BITS = (EXP_W > MOD_W) ? EXP_W : MOD_W;
  // step counter: counts operand bits during reduction, multiplier bits otherwise
  localparam int CNT_W = $clog2(OP_W);
  // exponent bit counter
  localparam int ECNT_W = $clog2(E_BITS);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(998244353);

  typedef enum logic [3:0] {
    CMD_REDUCE = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_MUL    = 4'd3,
    CMD_NEG    = 4'd4,
    CMD_POW    = 4'd5,
    CMD_INV    = 4'd6,
    CMD_DIV    = 4'd7,
    CMD_EQUAL  = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_EXEC,
    ST_SQR,
    ST_MULB,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

>>> sv/mau_mod_step.sv
// ----------------------------------------------------------------------------
// mau_mod_step: shared double-and-add modular step
// Returns (2*rem + addend) mod m for rem, addend below m, using two trial
// subtractions. Serves both operand reduction and shift-add multiplication.
// ----------------------------------------------------------------------------
module mau_mod_step (
  input  logic [mau_pkg::MOD_W-1:0] rem_i,
  input  logic [mau_pkg::MOD_W-1:0] addend_i,
  input  logic [mau_pkg::MOD_W-1:0] mod_i,
  output logic [mau_pkg::MOD_W-1:0] rem_o
);

  logic [mau_pkg::MOD_W+1:0] sum;
  logic [mau_pkg::MOD_W+1:0] mod_x1;
  logic [mau_pkg::MOD_W+1:0] mod_x2;
  logic [mau_pkg::MOD_W+1:0] diff1;
  logic [mau_pkg::MOD_W+1:0] diff2;

  // sum stays below three times the modulus
  assign sum    = {1'b0, rem_i, 1'b0} + {2'b00, addend_i};
  assign mod_x1 = {2'b00, mod_i};
  assign mod_x2 = {1'b0, mod_i, 1'b0};
  assign diff1  = sum - mod_x1;
  assign diff2  = sum - mod_x2;

  // pick the one candidate that lands in [0, m)
  always_comb begin
    if (sum >= mod_x2) begin
      rem_o = diff2[mau_pkg::MOD_W-1:0];
    end else if (sum >= mod_x1) begin
      rem_o = diff1[mau_pkg::MOD_W-1:0];
    end else begin
      rem_o = sum[mau_pkg::MOD_W-1:0];
    end
  end

endmodule

>>> sv/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: modular ALU with a configurable modulus
// Sequence per request: reduce |a| and |b| bit by bit (ST_RED_A, ST_RED_B), then one execute
// state that finishes reduce, add, sub, neg and equal; mul then runs a shift-add multiply. Pow, inv
// and div square for every exponent bit and multiply for every set bit; negative pow repeats this
// with exponent modulus-2, div ends in a multiply. Modulus below two goes straight to done.
// A new request is taken once idle again after the one-cycle strobe; reset sets modulus to 998244353.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        modulus_we_i,
  input  logic [mau_pkg::MOD_W-1:0]   modulus_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  cmd_i,
  input  logic [mau_pkg::OP_W-1:0]    operand_a_i,
  input  logic [mau_pkg::OP_W-1:0]    operand_b_i,
  input  logic [mau_pkg::OP_W-1:0]    exponent_i,
  output logic                        result_valid_o,
  output logic [mau_pkg::MOD_W-1:0]   result_o,
  output logic                        is_equal_o
);

  localparam int MW = mau_pkg::MOD_W;
  localparam int OW = mau_pkg::OP_W;
  localparam int EB = mau_pkg::E_BITS;
  localparam int CW = mau_pkg::CNT_W;
  localparam int EC = mau_pkg::ECNT_W;
  localparam int EXP_MSB = mau_pkg::EXP_W - 1;

  // control registers
  mau_pkg::state_e state_q, state_d;
  logic [MW-1:0]   mod_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [EC-1:0]   ecnt_q, ecnt_d;
  logic            pass_q, pass_d;

  // payload registers
  mau_pkg::cmd_e   cmd_q, cmd_d;
  logic            a_neg_q, a_neg_d;
  logic            b_neg_q, b_neg_d;
  logic            e_neg_q, e_neg_d;
  logic [OW-1:0]   b_mag_q, b_mag_d;
  logic [OW-1:0]   sh_q, sh_d;
  logic [EB-1:0]   e_q, e_d;
  logic [MW-1:0]   ra_q, ra_d;
  logic [MW-1:0]   rb_q, rb_d;
  logic [MW-1:0]   r_q, r_d;
  logic [MW-1:0]   mx_q, mx_d;
  logic [MW-1:0]   acc_q, acc_d;
  logic [MW-1:0]   base_q, base_d;
  logic [MW-1:0]   res_q, res_d;
  logic            eq_q, eq_d;

  // combinational helpers
  logic [MW-1:0]   addend;
  logic [MW-1:0]   step_out;
  logic [OW-1:0]   a_mag;
  logic [EXP_MSB:0] e_raw;
  logic [EXP_MSB:0] e_mag;
  logic [EB-1:0]   e_inv;
  logic            red_last;
  logic            mul_last;
  logic            exp_last;
  logic            mod_small;
  logic            next_pass;
  logic [MW:0]     add_sum;
  logic [MW:0]     sub_sum;
  logic [MW-1:0]   add_res;
  logic [MW-1:0]   sub_res;
  logic [MW-1:0]   neg_res;

  // signed value fix-up: residue of the magnitude turned into residue of -x
  function automatic logic [MW-1:0] fix_sign(logic [MW-1:0] r, logic neg, logic [MW-1:0] m);
    logic [MW-1:0] v;
    v = r;
    if (neg && (r != '0)) begin
      v = m - r;
    end
    return v;
  endfunction

  // shared arithmetic unit
  mau_mod_step u_step (
    .rem_i    (r_q),
    .addend_i (addend),
    .mod_i    (mod_q),
    .rem_o    (step_out)
  );

  // addend: operand bit during reduction, multiplicand during multiplies
  always_comb begin
    if (!sh_q[OW-1]) begin
      addend = '0;
    end else if ((state_q == mau_pkg::ST_RED_A) || (state_q == mau_pkg::ST_RED_B)) begin
      addend = MW'(1);
    end else begin
      addend = mx_q;
    end
  end

  // request decode and status terms
  assign a_mag     = operand_a_i[OW-1] ? (~operand_a_i + OW'(1)) : operand_a_i;
  assign e_raw     = exponent_i[EXP_MSB:0];
  assign e_mag     = e_raw[EXP_MSB] ? (~e_raw + (EXP_MSB+1)'(1)) : e_raw;
  assign e_inv     = EB'(mod_q - MW'(2));
  assign red_last  = (cnt_q == CW'(OW - 1));
  assign mul_last  = (cnt_q == CW'(MW - 1));
  assign exp_last  = (ecnt_q == EC'(EB - 1));
  assign mod_small = (mod_q < MW'(2));
  assign next_pass = (cmd_q == mau_pkg::CMD_POW) && e_neg_q && !pass_q;

  // simple opcodes
  assign add_sum = {1'b0, ra_q} + {1'b0, rb_q};
  assign sub_sum = {1'b0, ra_q} + ({1'b0, mod_q} - {1'b0, rb_q});
  assign add_res = (add_sum >= {1'b0, mod_q}) ? MW'(add_sum - {1'b0, mod_q}) : add_sum[MW-1:0];
  assign sub_res = (sub_sum >= {1'b0, mod_q}) ? MW'(sub_sum - {1'b0, mod_q}) : sub_sum[MW-1:0];
  assign neg_res = (ra_q != '0) ? (mod_q - ra_q) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mau_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mod_small ? mau_pkg::ST_DONE : mau_pkg::ST_RED_A;
        end
      end
      mau_pkg::ST_RED_A: begin
        if (red_last) state_d = mau_pkg::ST_RED_B;
      end
      mau_pkg::ST_RED_B: begin
        if (red_last) state_d = mau_pkg::ST_EXEC;
      end
      mau_pkg::ST_EXEC: begin
        case (cmd_q)
          mau_pkg::CMD_MUL: state_d = mau_pkg::ST_MUL;
          mau_pkg::CMD_POW,
          mau_pkg::CMD_INV,
          mau_pkg::CMD_DIV: state_d = mau_pkg::ST_SQR;
          default:          state_d = mau_pkg::ST_DONE;
        endcase
      end
      mau_pkg::ST_SQR,
      mau_pkg::ST_MULB: begin
        if (mul_last) begin
          if ((state_q == mau_pkg::ST_SQR) && e_q[EB-1]) begin
            state_d = mau_pkg::ST_MULB;
          end else if (!exp_last) begin
            state_d = mau_pkg::ST_SQR;
          end else if (next_pass) begin
            state_d = mau_pkg::ST_SQR;
          end else if (cmd_q == mau_pkg::CMD_DIV) begin
            state_d = mau_pkg::ST_MUL;
          end else begin
            state_d = mau_pkg::ST_DONE;
          end
        end
      end
      mau_pkg::ST_MUL: begin
        if (mul_last) state_d = mau_pkg::ST_DONE;
      end
      mau_pkg::ST_DONE: begin
        state_d = mau_pkg::ST_IDLE;
      end
      default: state_d = mau_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy           = (state_q != mau_pkg::ST_IDLE);
    result_valid_o = (state_q == mau_pkg::ST_DONE);
  end

  assign result_o   = res_q;
  assign is_equal_o = eq_q;

  // datapath next values
  always_comb begin
    cmd_d   = cmd_q;
    a_neg_d = a_neg_q;
    b_neg_d = b_neg_q;
    e_neg_d = e_neg_q;
    b_mag_d = b_mag_q;
    sh_d    = sh_q;
    e_d     = e_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    r_d     = r_q;
    mx_d    = mx_q;
    acc_d   = acc_q;
    base_d  = base_q;
    res_d   = res_q;
    eq_d    = eq_q;
    cnt_d   = cnt_q;
    ecnt_d  = ecnt_q;
    pass_d  = pass_q;

    unique case (state_q)
      mau_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d   = mau_pkg::cmd_e'(cmd_i);
          a_neg_d = operand_a_i[OW-1];
          b_neg_d = operand_b_i[OW-1];
          b_mag_d = operand_b_i[OW-1] ? (~operand_b_i + OW'(1)) : operand_b_i;
          e_neg_d = e_raw[EXP_MSB];
          e_d     = EB'(e_mag);
          sh_d    = a_mag;
          r_d     = '0;
          cnt_d   = '0;
          res_d   = '0;
          eq_d    = mod_small && (cmd_i == mau_pkg::CMD_EQUAL);
        end
      end

      // reduce |a| then |b| one bit a cycle, MSB first
      mau_pkg::ST_RED_A,
      mau_pkg::ST_RED_B: begin
        r_d   = step_out;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (red_last) begin
          r_d   = '0;
          cnt_d = '0;
          if (state_q == mau_pkg::ST_RED_A) begin
            ra_d = fix_sign(step_out, a_neg_q, mod_q);
            sh_d = b_mag_q;
          end else begin
            rb_d = fix_sign(step_out, b_neg_q, mod_q);
          end
        end
      end

      // results of the simple opcodes, or launch of the multiply / power sequence
      mau_pkg::ST_EXEC: begin
        r_d   = '0;
        cnt_d = '0;
        case (cmd_q)
          mau_pkg::CMD_REDUCE: res_d = ra_q;
          mau_pkg::CMD_ADD:    res_d = add_res;
          mau_pkg::CMD_SUB:    res_d = sub_res;
          mau_pkg::CMD_NEG:    res_d = neg_res;
          mau_pkg::CMD_EQUAL: begin
            res_d = '0;
            eq_d  = (ra_q == rb_q);
          end
          mau_pkg::CMD_MUL: begin
            mx_d = ra_q;
            sh_d = {rb_q, {(OW-MW){1'b0}}};
          end
          mau_pkg::CMD_POW,
          mau_pkg::CMD_INV,
          mau_pkg::CMD_DIV: begin
            acc_d  = MW'(1);
            ecnt_d = '0;
            pass_d = 1'b0;
            mx_d   = MW'(1);
            sh_d   = {MW'(1), {(OW-MW){1'b0}}};
            if (cmd_q == mau_pkg::CMD_DIV) begin
              base_d = rb_q;
            end else begin
              base_d = ra_q;
            end
            if (cmd_q != mau_pkg::CMD_POW) begin
              e_d = e_inv;
            end
          end
          default: res_d = '0;
        endcase
      end

      // square-and-multiply, exponent MSB first
      mau_pkg::ST_SQR,
      mau_pkg::ST_MULB: begin
        r_d   = step_out;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          acc_d = step_out;
          r_d   = '0;
          cnt_d = '0;
          if ((state_q == mau_pkg::ST_SQR) && e_q[EB-1]) begin
            mx_d = base_q;
            sh_d = {step_out, {(OW-MW){1'b0}}};
          end else begin
            e_d    = e_q << 1;
            ecnt_d = ecnt_q + EC'(1);
            if (!exp_last) begin
              mx_d = step_out;
              sh_d = {step_out, {(OW-MW){1'b0}}};
            end else if (next_pass) begin
              // inverse of the positive power
              pass_d = 1'b1;
              base_d = step_out;
              acc_d  = MW'(1);
              e_d    = e_inv;
              ecnt_d = '0;
              mx_d   = MW'(1);
              sh_d   = {MW'(1), {(OW-MW){1'b0}}};
            end else if (cmd_q == mau_pkg::CMD_DIV) begin
              mx_d = ra_q;
              sh_d = {step_out, {(OW-MW){1'b0}}};
            end else begin
              res_d = step_out;
            end
          end
        end
      end

      // plain multiply
      mau_pkg::ST_MUL: begin
        r_d   = step_out;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          res_d = step_out;
          cnt_d = '0;
        end
      end

      mau_pkg::ST_DONE: begin
        cnt_d = '0;
      end

      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // control state and modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mau_pkg::ST_IDLE;
      mod_q   <= mau_pkg::MOD_RESET;
      cnt_q   <= '0;
      ecnt_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ecnt_q  <= ecnt_d;
      pass_q  <= pass_d;
      if (modulus_we_i) begin
        mod_q <= modulus_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    a_neg_q <= a_neg_d;
    b_neg_q <= b_neg_d;
    e_neg_q <= e_neg_d;
    b_mag_q <= b_mag_d;
    sh_q    <= sh_d;
    e_q     <= e_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    r_q     <= r_d;
    mx_q    <= mx_d;
    acc_q   <= acc_d;
    base_q  <= base_d;
    res_q   <= res_d;
    eq_q    <= eq_d;
  end

endmodule
